FILE: hdl/swmf_pkg.sv
// Shared constants, types and helpers for the sliding window median filter.
`default_nettype none

package swmf_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int MAX_HALF    = 15;
  localparam int DEPTH       = 2 * MAX_HALF + 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int HALF_W      = 4;
  localparam int MODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 4;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [IDX_W-1:0]       tag_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [HALF_W-1:0]      half_t;
  typedef logic [MODE_W-1:0]      mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HALF_WIDTH    = 2'd0,
    REG_BOUNDARY_MODE = 2'd1,
    REG_SAMPLE_SIGNED = 2'd2
  } cfg_reg_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CENTRED   = 2'd0,
    MODE_SYMMETRIC = 2'd1,
    MODE_TRAILING  = 2'd2
  } bmode_t;

  typedef struct packed {
    sample_t sample;
    tag_t    tag_new;
    tag_t    head;
    logic    ins_en;
    logic    del_en;
    logic    sgn;
  } cell_ctrl_t;

  typedef struct packed {
    sample_t value;
    tag_t    tag;
    logic    le;
  } cell_link_t;

  typedef struct packed {
    logic go;
    tag_t idx;
    logic last;
  } emit_t;

  localparam cell_link_t LINK_FLOOR = '{value: '0, tag: '0, le: 1'b1};
  localparam cell_link_t LINK_CEIL  = '{value: '0, tag: '0, le: 1'b0};

  function automatic sample_t order_key(sample_t v, logic sgn);
    sample_t m;
    m = '0;
    m[SAMPLE_BITS-1] = sgn;
    return v ^ m;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/swmf_if.sv
// Channel interfaces: sample input, median output and configuration write.
`default_nettype none

interface swmf_in_if;
  logic              valid;
  logic              ready;
  swmf_pkg::sample_t sample;
  logic              end_of_stream;
  modport source (output valid, sample, end_of_stream, input ready);
  modport sink   (input valid, sample, end_of_stream, output ready);
endinterface

interface swmf_out_if;
  logic              valid;
  logic              ready;
  swmf_pkg::sample_t median;
  logic              last_result;
  modport source (output valid, median, last_result, input ready);
  modport sink   (input valid, median, last_result, output ready);
endinterface

interface swmf_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [swmf_pkg::CFG_IDX_W-1:0]  index;
  logic [swmf_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: hdl/swmf_cell.sv
// One cell of the sorted chain: holds one sample and its ring tag.
`default_nettype none

module swmf_cell (
  input  logic                 clk,
  input  swmf_pkg::cell_ctrl_t ctrl,
  input  logic                 occupied,
  input  swmf_pkg::cell_link_t below,
  input  swmf_pkg::cell_link_t above,
  input  logic                 del_below,
  output logic                 del_upto,
  output swmf_pkg::cell_link_t link
);

  swmf_pkg::sample_t    value_r, value_nxt;
  swmf_pkg::tag_t       tag_r, tag_nxt;
  logic                 le;
  logic                 del_here;
  swmf_pkg::cell_link_t self_link;
  swmf_pkg::cell_link_t keep;
  swmf_pkg::cell_link_t lower;
  swmf_pkg::cell_link_t fresh;
  swmf_pkg::cell_link_t pick;

  always_comb begin
    le = occupied && (swmf_pkg::order_key(value_r, ctrl.sgn) <=
                      swmf_pkg::order_key(ctrl.sample, ctrl.sgn));
    del_here  = ctrl.del_en && occupied && (tag_r == ctrl.head);
    del_upto  = del_below || del_here;
    self_link = '{value: value_r, tag: tag_r, le: le};
    // close the gap left by the dropped word, then open one for the new word
    keep  = del_upto  ? above     : self_link;
    lower = del_below ? self_link : below;
    fresh = '{value: ctrl.sample, tag: ctrl.tag_new, le: 1'b1};
    if (!ctrl.ins_en || keep.le) begin
      pick = keep;
    end else if (lower.le) begin
      pick = fresh;
    end else begin
      pick = lower;
    end
    value_nxt = pick.value;
    tag_nxt   = pick.tag;
  end

  assign link = self_link;

  always_ff @(posedge clk) begin
    if (ctrl.ins_en || ctrl.del_en) begin
      value_r <= value_nxt;
      tag_r   <= tag_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/swmf_ctrl.sv
// Stream sequencer: window counters, drain steps and configuration registers.
`default_nettype none

module swmf_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  swmf_pkg::sample_t                in_sample,
  input  logic                             in_eos,
  output logic                             in_ready,
  input  logic                             op_ok,
  input  logic                             cfg_valid,
  input  logic [swmf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swmf_pkg::CFG_DATA_W-1:0] cfg_data,
  output swmf_pkg::cell_ctrl_t             cell_ctrl,
  output swmf_pkg::cnt_t                   held,
  output swmf_pkg::emit_t                  emit
);

  localparam int SUM_W = swmf_pkg::CNT_W + 1;

  typedef enum logic {ST_RUN, ST_DRAIN} state_t;

  state_t            state_r, state_nxt;
  swmf_pkg::cnt_t    held_r, held_nxt;
  swmf_pkg::tag_t    head_r, head_nxt;
  swmf_pkg::cnt_t    seen_r, seen_nxt;
  swmf_pkg::half_t   drain_cnt_r, drain_cnt_nxt;
  logic              sub_r, sub_nxt;
  swmf_pkg::half_t   half_r, half_nxt;
  swmf_pkg::mode_t   mode_r, mode_nxt;
  logic              sgn_r, sgn_nxt;

  swmf_pkg::half_t   w;
  logic              is_sym;
  logic              is_trail;
  swmf_pkg::cnt_t    win;
  swmf_pkg::cnt_t    thr;
  logic              full;
  swmf_pkg::tag_t    head_inc;
  logic [SUM_W-1:0]  tag_sum;
  swmf_pkg::tag_t    tag_new;
  swmf_pkg::cnt_t    held_a;
  swmf_pkg::cnt_t    held_d;
  swmf_pkg::cnt_t    seen_a;
  logic              drain_ok;
  logic              clear;

  always_comb begin
    w        = half_r;
    is_sym   = (mode_r == swmf_pkg::MODE_SYMMETRIC);
    is_trail = (mode_r == swmf_pkg::MODE_TRAILING);
    if (is_trail) begin
      win = (w == '0) ? swmf_pkg::cnt_t'(1) : swmf_pkg::cnt_t'(w);
    end else begin
      win = swmf_pkg::cnt_t'({w, 1'b1});
    end
    thr      = is_sym ? swmf_pkg::cnt_t'(3) : swmf_pkg::cnt_t'(2);
    full     = (held_r >= win);
    head_inc = (head_r == swmf_pkg::tag_t'(swmf_pkg::DEPTH - 1)) ?
               '0 : head_r + swmf_pkg::tag_t'(1);
    tag_sum  = SUM_W'(head_r) + SUM_W'(held_r);
    tag_new  = (tag_sum >= SUM_W'(swmf_pkg::DEPTH)) ?
               swmf_pkg::tag_t'(tag_sum - SUM_W'(swmf_pkg::DEPTH)) :
               swmf_pkg::tag_t'(tag_sum);
    held_a   = full ? held_r : held_r + swmf_pkg::cnt_t'(1);
    held_d   = held_r - swmf_pkg::cnt_t'(1);
    seen_a   = (seen_r < win) ? seen_r + swmf_pkg::cnt_t'(1) : seen_r;
    in_ready = (state_r == ST_RUN) && op_ok;

    state_nxt     = state_r;
    held_nxt      = held_r;
    head_nxt      = head_r;
    seen_nxt      = seen_r;
    drain_cnt_nxt = drain_cnt_r;
    sub_nxt       = sub_r;
    half_nxt      = half_r;
    mode_nxt      = mode_r;
    sgn_nxt       = sgn_r;
    drain_ok      = 1'b0;
    clear         = 1'b0;
    cell_ctrl     = '{sample: in_sample, tag_new: tag_new, head: head_r,
                      ins_en: 1'b0, del_en: 1'b0, sgn: sgn_r};
    emit          = '0;

    if (cfg_valid) begin
      case (cfg_index)
        swmf_pkg::REG_HALF_WIDTH: begin
          half_nxt = cfg_data[swmf_pkg::HALF_W-1:0];
          clear    = 1'b1;
        end
        swmf_pkg::REG_BOUNDARY_MODE: begin
          mode_nxt = cfg_data[swmf_pkg::MODE_W-1:0];
          clear    = 1'b1;
        end
        swmf_pkg::REG_SAMPLE_SIGNED: begin
          sgn_nxt = cfg_data[0];
          clear   = 1'b1;
        end
        default: begin
        end
      endcase
    end else if (state_r == ST_RUN) begin
      if (in_valid && op_ok) begin
        cell_ctrl.ins_en = 1'b1;
        cell_ctrl.del_en = full;
        held_nxt = held_a;
        head_nxt = full ? head_inc : head_r;
        seen_nxt = seen_a;
        if (is_trail) begin
          emit.go = 1'b1;
        end else if (is_sym) begin
          emit.go = seen_a[0];
        end else begin
          emit.go = (seen_a >= swmf_pkg::cnt_t'(w) + swmf_pkg::cnt_t'(1));
        end
        emit.idx = swmf_pkg::tag_t'((held_a - swmf_pkg::cnt_t'(1)) >> 1);
        if (in_eos) begin
          drain_ok  = !is_trail && (w != '0) && (held_a >= thr);
          emit.last = emit.go && !drain_ok;
          if (drain_ok) begin
            state_nxt     = ST_DRAIN;
            drain_cnt_nxt = w;
            sub_nxt       = 1'b0;
          end else begin
            clear = 1'b1;
          end
        end
      end
    end else if (op_ok) begin
      cell_ctrl.del_en = 1'b1;
      held_nxt = held_d;
      head_nxt = head_inc;
      if (is_sym && !sub_r) begin
        sub_nxt = 1'b1;
      end else begin
        sub_nxt       = 1'b0;
        emit.go       = 1'b1;
        emit.idx      = swmf_pkg::tag_t'((held_d - swmf_pkg::cnt_t'(1)) >> 1);
        emit.last     = (drain_cnt_r == swmf_pkg::half_t'(1)) || (held_d < thr);
        drain_cnt_nxt = drain_cnt_r - swmf_pkg::half_t'(1);
        clear         = emit.last;
      end
    end

    if (clear) begin
      state_nxt     = ST_RUN;
      held_nxt      = '0;
      head_nxt      = '0;
      seen_nxt      = '0;
      drain_cnt_nxt = '0;
      sub_nxt       = 1'b0;
    end
  end

  assign held = held_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      held_r      <= '0;
      head_r      <= '0;
      seen_r      <= '0;
      drain_cnt_r <= '0;
      sub_r       <= 1'b0;
      half_r      <= swmf_pkg::half_t'(1);
      mode_r      <= swmf_pkg::MODE_CENTRED;
      sgn_r       <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      head_r      <= head_nxt;
      seen_r      <= seen_nxt;
      drain_cnt_r <= drain_cnt_nxt;
      sub_r       <= sub_nxt;
      half_r      <= half_nxt;
      mode_r      <= mode_nxt;
      sgn_r       <= sgn_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/sliding_window_median_filter.sv
// Top level of the sliding window median filter: sorted cell chain and output stage.
// An accepted sample updates the cell chain and, if a median is due, the selection;
//   that median is copied to the output register once that register is empty or read.
// Throughput: one sample per cycle unless the output stage stalls; a closing sample
//   adds up to w drain steps in mode 0 and 2w in mode 1, one oldest-sample delete each.
// Reset: synchronous, active low; clears stream counters and handshake state and
//   loads half_width 1, boundary_mode 0, sample_signed 1. Cell contents stay undefined.
`default_nettype none

module sliding_window_median_filter (
  input  logic        clk,
  input  logic        rst_n,
  swmf_in_if.sink     in_ch,
  swmf_out_if.source  out_ch,
  swmf_cfg_if.sink    cfg_ch
);

  swmf_pkg::cell_ctrl_t          cell_ctrl;
  swmf_pkg::cnt_t                held;
  swmf_pkg::emit_t               emit;
  swmf_pkg::cell_link_t          links [swmf_pkg::DEPTH];
  logic [swmf_pkg::DEPTH-1:0]    del_upto;
  logic                          op_ok;
  logic                          sel_move;

  logic                          sel_v_r, sel_v_nxt;
  swmf_pkg::tag_t                sel_idx_r, sel_idx_nxt;
  logic                          sel_last_r, sel_last_nxt;
  logic                          out_valid_r, out_valid_nxt;
  swmf_pkg::sample_t             out_median_r, out_median_nxt;
  logic                          out_last_r, out_last_nxt;

  assign cfg_ch.ready = 1'b1;
  assign sel_move     = sel_v_r && (!out_valid_r || out_ch.ready);
  assign op_ok        = !sel_v_r || sel_move;

  swmf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_sample (in_ch.sample),
    .in_eos    (in_ch.end_of_stream),
    .in_ready  (in_ch.ready),
    .op_ok     (op_ok),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cell_ctrl (cell_ctrl),
    .held      (held),
    .emit      (emit)
  );

  for (genvar j = 0; j < swmf_pkg::DEPTH; j++) begin : g_cell
    swmf_pkg::cell_link_t below;
    swmf_pkg::cell_link_t above;
    logic                 del_below;
    logic                 occupied;

    if (j == 0) begin : g_floor
      assign below     = swmf_pkg::LINK_FLOOR;
      assign del_below = 1'b0;
    end else begin : g_mid
      assign below     = links[j-1];
      assign del_below = del_upto[j-1];
    end

    if (j == swmf_pkg::DEPTH - 1) begin : g_ceil
      assign above = swmf_pkg::LINK_CEIL;
    end else begin : g_low
      assign above = links[j+1];
    end

    assign occupied = (swmf_pkg::cnt_t'(j) < held);

    swmf_cell u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .occupied  (occupied),
      .below     (below),
      .above     (above),
      .del_below (del_below),
      .del_upto  (del_upto[j]),
      .link      (links[j])
    );
  end

  always_comb begin
    sel_v_nxt      = sel_v_r;
    sel_idx_nxt    = sel_idx_r;
    sel_last_nxt   = sel_last_r;
    out_valid_nxt  = out_valid_r;
    out_median_nxt = out_median_r;
    out_last_nxt   = out_last_r;
    if (sel_move) begin
      out_valid_nxt  = 1'b1;
      out_median_nxt = links[sel_idx_r].value;
      out_last_nxt   = sel_last_r;
      sel_v_nxt      = 1'b0;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (emit.go) begin
      sel_v_nxt    = 1'b1;
      sel_idx_nxt  = emit.idx;
      sel_last_nxt = emit.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      sel_v_r     <= sel_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
    sel_idx_r    <= sel_idx_nxt;
    sel_last_r   <= sel_last_nxt;
    out_median_r <= out_median_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.median      = out_median_r;
  assign out_ch.last_result = out_last_r;

endmodule

`default_nettype wire

FILE: hdl/swmf_checker.sv
// Port-level assertions for the median filter, bound to the top level.
`default_nettype none

module swmf_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input swmf_pkg::sample_t out_median,
  input logic              out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_median) && $stable(out_last))
    else $error("stalled result word changed");

  a_rst_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_rst_ready: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready after reset");

  a_rst_latency: assert property (@(posedge clk)
    !rst_n ##1 rst_n |-> !out_valid ##1 !out_valid)
    else $error("result appeared too early after reset");

endmodule

bind sliding_window_median_filter swmf_checker u_swmf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_median (out_ch.median),
  .out_last   (out_ch.last_result)
);

`default_nettype wire
